FILE: hw/rtl/tcw_pkg.sv
// Shared types, constants and codes of the text console writer.
package tcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF = 25;

	localparam int unsigned ATTR_W = 8;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CELL_W = 16;
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned CURSOR_COL_W = 7;
	localparam int unsigned CURSOR_ROW_W = 5;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTR = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_ATTR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FILL_ATTR = 2'd2;

	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST = 8'd15;
	localparam logic [ATTR_W-1:0] CLEAR_ATTR_RST = 8'd0;
	localparam logic [ATTR_W-1:0] FILL_ATTR_RST = 8'd7;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [CHAR_W-1:0]  char_code;
		logic [INDEX_W-1:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0]       cell_data;
		logic [CURSOR_COL_W-1:0] cursor_column;
		logic [CURSOR_ROW_W-1:0] cursor_line;
		logic                    did_scroll;
	} rsp_t;

	typedef struct packed {
		logic [ATTR_W-1:0] text_attribute;
		logic [ATTR_W-1:0] clear_attribute;
		logic [ATTR_W-1:0] scroll_fill_attribute;
	} attr_cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK,
		ST_RESULT
	} state_t;

endpackage

FILE: hw/rtl/tcw_engine.sv
// Cell memory, cursor and command sequencer of the text console writer.
module tcw_engine #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::attr_cfg_t  cfg,
	input  logic                req_valid,
	output logic                req_ready,
	input  tcw_pkg::req_t       req,
	output logic                res_valid,
	input  logic                res_take,
	output tcw_pkg::rsp_t       res
);
	import tcw_pkg::*;

	localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
	localparam int unsigned AW = $clog2(CELL_COUNT);
	localparam int unsigned CW = $clog2(COLUMNS);
	localparam int unsigned RW = $clog2(ROWS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] LAST_BASE = AW'(CELL_COUNT - COLUMNS);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic [CELL_W-1:0] cells_mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_s1;

	state_t state_q, state_d;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          scrolled_q;
	logic          rd_hit_q;
	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;

	logic              accept;
	logic              is_put;
	logic              is_nl;
	logic              wrap;
	logic              at_row_end;
	logic              need_scroll;
	logic              in_range;
	logic [AW-1:0]     pos;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign is_put = (req.command == CMD_PUT);
	assign is_nl = (req.char_code == NEWLINE_CODE);
	assign wrap = is_nl || (col_q == LAST_COL);
	assign at_row_end = (row_q == LAST_ROW);
	assign need_scroll = is_put && wrap && at_row_end;
	assign in_range = (32'(req.cell_index) < 32'(CELL_COUNT));
	assign pos = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (ptr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.command == CMD_CLEAR) state_d = ST_CLEAR;
					else if (need_scroll) state_d = ST_SCROLL;
					else state_d = ST_RESULT;
				end
			end
			ST_CLEAR: begin
				if (ptr_q == LAST_ADDR) state_d = ST_RESULT;
			end
			ST_SCROLL: begin
				if (ptr_q == LAST_BASE) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (ptr_q == LAST_ADDR) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q;
			end
			ST_IDLE: begin
				if (accept && is_put && !is_nl) begin
					mem_we = 1'b1;
					mem_waddr = pos;
					mem_wdata = {cfg.text_attribute, req.char_code};
				end
				if (accept && (req.command == CMD_READ) && in_range) begin
					mem_re = 1'b1;
					mem_raddr = AW'(req.cell_index);
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = {cfg.clear_attribute, SPACE_CODE};
			end
			ST_SCROLL: begin
				if (ptr_q != LAST_BASE) begin
					mem_re = 1'b1;
					mem_raddr = ptr_q + AW'(COLUMNS);
				end
				if (wr_valid_s1) begin
					mem_we = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = rdata_s1;
				end
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = {cfg.scroll_fill_attribute, SPACE_CODE};
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) cells_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= cells_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			scrolled_q <= 1'b0;
			rd_hit_q <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_valid_s1 <= (state_q == ST_SCROLL) && (ptr_q != LAST_BASE);
			case (state_q)
				ST_INIT, ST_CLEAR, ST_BLANK: begin
					ptr_q <= (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
				end
				ST_SCROLL: begin
					if (ptr_q != LAST_BASE) ptr_q <= ptr_q + 1'b1;
				end
				default: ptr_q <= '0;
			endcase
			if (accept) begin
				rd_hit_q <= (req.command == CMD_READ) && in_range;
				scrolled_q <= need_scroll;
				if (req.command == CMD_CLEAR) begin
					col_q <= '0;
					row_q <= '0;
				end else if (is_put) begin
					if (wrap) begin
						col_q <= '0;
						if (!at_row_end) row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	assign res_valid = (state_q == ST_RESULT);
	assign res.cell_data = rd_hit_q ? rdata_s1 : '0;
	assign res.cursor_column = CURSOR_COL_W'(col_q);
	assign res.cursor_line = CURSOR_ROW_W'(row_q);
	assign res.did_scroll = scrolled_q;

`ifndef SYNTHESIS
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)))
		else $error("Cursor left the grid.");

	a_result_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> (!mem_we && !mem_re))
		else $error("Memory accessed while a result is held.");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid_s1 |-> (state_q == ST_SCROLL))
		else $error("Scroll copy write left pending after the scroll pass.");

	a_blank_reports_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_BLANK) && (state_d == ST_RESULT)) |=> (res_valid && scrolled_q))
		else $error("Finished scroll not reported in the result.");
`endif

endmodule

FILE: hw/rtl/text_console_writer_core.sv
// Text console writer: a ROWS x COLUMNS grid of 16-bit cells (attribute in the high byte,
// character in the low byte) held in one synchronous memory with a cursor, driven by clear,
// put-character and read commands that each return one transfer with the cursor after the
// command. A read, an unused command, and a put that does not scroll go through a result state,
// and no new item is accepted until that result is taken. A clear writes one cell per cycle.
// A put that scrolls copies one cell per cycle through the single read and write ports of the
// memory, then blanks the bottom row. After reset the memory is swept to zero, one cell per
// cycle, and no item is accepted during the sweep; attribute registers may be written at any
// time the block is idle, including then.
module text_console_writer_core #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tcw_pkg::ATTR_W-1:0]        cfg_wdata,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  tcw_pkg::req_t                     req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output tcw_pkg::rsp_t                     rsp_data
);
	import tcw_pkg::*;

	attr_cfg_t cfg_q;
	logic      eng_ready;
	logic      eng_valid;
	rsp_t      eng_res;
	logic      take;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_attribute <= TEXT_ATTR_RST;
			cfg_q.clear_attribute <= CLEAR_ATTR_RST;
			cfg_q.scroll_fill_attribute <= FILL_ATTR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_ATTR: cfg_q.text_attribute <= cfg_wdata;
				REG_CLEAR_ATTR: cfg_q.clear_attribute <= cfg_wdata;
				REG_FILL_ATTR: cfg_q.scroll_fill_attribute <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	tcw_engine #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.req_valid(req_valid),
		.req_ready(eng_ready),
		.req(req_data),
		.res_valid(eng_valid),
		.res_take(take),
		.res(eng_res)
	);

	assign req_stall = !eng_ready;
	assign take = eng_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) rsp_q <= eng_res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule
